// File: src/tssg_pkg.sv
`timescale 1ns / 1ps

package tssg_pkg;

  // Field and register widths
  localparam int TIME_W    = 32;
  localparam int FREQ_W    = 24;
  localparam int FRAC_W    = 16;
  localparam int ANG_W     = 16;
  localparam int PAIR_W    = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int CYC_W     = 32;   // cycle fraction, Q0.32
  localparam int TRI_W     = 33;   // triangle value, signed Q2.30 with headroom
  localparam int SHP_W     = 36;   // shaped term before amplitude
  localparam int PRD_W     = 52;   // amplitude times shaped term
  localparam int ACC_W     = 56;   // sum at Q.31 scale
  localparam int VAL_W     = ACC_W - 31;

  // Pipeline depths
  localparam int PH_LAT    = 9;
  localparam int DIV_STEPS = 30;
  localparam int TRI_LAT   = DIV_STEPS + 2;
  localparam int SHP_LAT   = 4;
  localparam int PIPE_LAT  = PH_LAT + TRI_LAT + SHP_LAT;

  // Cycle position: t*F / (1e6 * 2^16) = t*F*2^10 / 15625 in units of 2^-32 of a waveform period
  localparam logic [13:0] CYC_DIV   = 14'd15625;
  localparam logic [11:0] POW16_MOD = 12'd3036;        // 2^16 mod 15625
  localparam logic [28:0] RECIP     = 29'd281474977;   // ceil(2^42 / 15625)
  localparam int          RECIP_SH  = 42;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQUENCY  = 8'd0,
    REG_PHASE      = 8'd1,
    REG_OFFSET     = 8'd2,
    REG_AMPLITUDE  = 8'd3,
    REG_SKEW       = 8'd4,
    REG_SQUARENESS = 8'd5,
    REG_ANGLE_MIN  = 8'd6,
    REG_ANGLE_MAX  = 8'd7
  } cfg_reg_t;

  // Term selection flags of one asymmetric triangle
  typedef struct packed {
    logic t1div;   // rising part by division
    logic t1eq;    // rising part at its edge: half step
    logic t1neg;   // sawtooth negative
    logic rlt;     // reversed saw below -a: falling part, positive
    logic rgt;     // reversed saw above +a: falling part, negative
    logic reqn;    // reversed saw exactly -a
    logic reqp;    // reversed saw exactly +a
  } tri_flags_t;

  // Quotient by 15625 for x < 2^28 (reciprocal product, exact in that range)
  function automatic logic [14:0] div15625(input logic [27:0] x);
    logic [56:0] p;
    p = 57'(x) * 57'(RECIP);
    return p[56:RECIP_SH];
  endfunction

  // Remainder from a quotient computed above
  function automatic logic [13:0] mod15625(input logic [27:0] x, input logic [14:0] q);
    logic [27:0] qd;
    qd = 28'(q) * 28'(CYC_DIV);
    return 14'(x - qd);
  endfunction

  // Inverse of 15625 modulo 2^22 (Newton iteration, elaboration only)
  function automatic logic [21:0] inv_mod22();
    logic [63:0] d;
    logic [63:0] x;
    d = 64'(CYC_DIV);
    x = d;
    for (int k = 0; k < 4; k++) begin
      x = x * (64'd2 - d * x);
    end
    return x[21:0];
  endfunction

  localparam logic [21:0] INV22 = inv_mod22();

endpackage

// File: src/tssg_phase.sv
`timescale 1ns / 1ps

module tssg_phase (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tssg_pkg::TIME_W-1:0]   t,
  input  logic [tssg_pkg::FREQ_W-1:0]   frequency,
  input  logic [tssg_pkg::FRAC_W-1:0]   phase_shift,
  output logic [tssg_pkg::CYC_W-1:0]    u
);
  import tssg_pkg::*;

  logic [TIME_W-1:0] t1_r;
  logic [PH_LAT-2:0] tnz_r;
  logic [27:0]       tx2_r, tx3_r;
  logic [19:0]       fx2_r, fx3_r;
  logic [21:0]       pl2_r, pl3_r, pl4_r, pl5_r, pl6_r, pl7_r;
  logic [14:0]       tq3_r, fq3_r, pq6_r;
  logic [13:0]       tm4_r, fm4_r, r7_r, r8_r;
  logic [27:0]       pm5_r, pm6_r;
  logic [21:0]       q8_r;
  logic [CYC_W-1:0]  u_r;

  logic [43:0]       pl_full;
  logic [43:0]       q_full;
  logic [21:0]       diff;
  logic [14:0]       f_q;
  logic [CYC_W-1:0]  ph_add;

  // Low bits of t*F and of the exact quotient by 15625
  assign pl_full = 44'(t1_r[21:0]) * 44'(frequency[21:0]);
  assign diff    = pl7_r - 22'(r7_r);
  assign q_full  = 44'(diff) * 44'(INV22);
  // Fractional part of (t*F mod 15625) / 15625 in 10 bits
  assign f_q     = div15625(28'({r8_r, 10'd0}));
  assign ph_add  = tnz_r[PH_LAT-2] ? {phase_shift, 16'd0} : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: capture
      t1_r  <= t;
      tnz_r <= {tnz_r[PH_LAT-3:0], (t != '0)};
      // stage 2: fold high halves, low product
      tx2_r <= 28'(28'(t1_r[31:16]) * 28'(POW16_MOD)) + 28'(t1_r[15:0]);
      fx2_r <= 20'(20'(frequency[23:16]) * 20'(POW16_MOD)) + 20'(frequency[15:0]);
      pl2_r <= pl_full[21:0];
      // stage 3: quotients
      tq3_r <= div15625(tx2_r);
      fq3_r <= div15625(28'(fx2_r));
      tx3_r <= tx2_r;
      fx3_r <= fx2_r;
      pl3_r <= pl2_r;
      // stage 4: residues of t and F
      tm4_r <= mod15625(tx3_r, tq3_r);
      fm4_r <= mod15625(28'(fx3_r), fq3_r);
      pl4_r <= pl3_r;
      // stage 5: residue product
      pm5_r <= 28'(tm4_r) * 28'(fm4_r);
      pl5_r <= pl4_r;
      // stage 6-7: residue of t*F
      pq6_r <= div15625(pm5_r);
      pm6_r <= pm5_r;
      pl6_r <= pl5_r;
      r7_r  <= mod15625(pm6_r, pq6_r);
      pl7_r <= pl6_r;
      // stage 8: quotient low bits by the odd inverse
      q8_r  <= q_full[21:0];
      r8_r  <= r7_r;
      // stage 9: assemble fraction, add phase
      u_r   <= {q8_r, f_q[9:0]} + ph_add;
    end
  end

  assign u = u_r;

endmodule

// File: src/tssg_div.sv
`timescale 1ns / 1ps

module tssg_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [15:0]                      r0,   // upper numerator bits, below d
  input  logic [tssg_pkg::DIV_STEPS-1:0]   lo,   // remaining numerator bits
  input  logic [16:0]                      d,
  output logic [tssg_pkg::DIV_STEPS-1:0]   q
);
  import tssg_pkg::*;

  logic [16:0]          rem_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] num_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r   [DIV_STEPS];
  logic [16:0]          src_rem [DIV_STEPS];
  logic [DIV_STEPS-1:0] src_num [DIV_STEPS];
  logic [DIV_STEPS-1:0] src_quo [DIV_STEPS];
  logic [17:0]          trial   [DIV_STEPS];
  logic                 ge      [DIV_STEPS];

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign src_rem[k] = {1'b0, r0};
      assign src_num[k] = lo;
      assign src_quo[k] = '0;
    end else begin : g_next
      assign src_rem[k] = rem_r[k-1];
      assign src_num[k] = num_r[k-1];
      assign src_quo[k] = quo_r[k-1];
    end

    assign trial[k] = {src_rem[k], src_num[k][DIV_STEPS-1]};
    assign ge[k]    = trial[k] >= {1'b0, d};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge[k] ? 17'(trial[k] - {1'b0, d}) : trial[k][16:0];
        num_r[k] <= {src_num[k][DIV_STEPS-2:0], 1'b0};
        quo_r[k] <= {src_quo[k][DIV_STEPS-2:0], ge[k]};
      end
    end
  end

  assign q = quo_r[DIV_STEPS-1];

endmodule

// File: src/tssg_tri.sv
`timescale 1ns / 1ps

module tssg_tri (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tssg_pkg::CYC_W-1:0]        u,
  input  logic [tssg_pkg::FRAC_W-1:0]       a,
  output logic signed [tssg_pkg::TRI_W-1:0] tv
);
  import tssg_pkg::*;

  localparam logic signed [TRI_W-1:0] ONE31 = 33'sh0_8000_0000;
  localparam logic signed [TRI_W-1:0] HALF  = 33'sh0_2000_0000;

  logic signed [TRI_W-1:0] saw, rev, a31, abs_saw;
  logic [CYC_W-1:0]        rev_u;
  tri_flags_t              fl;
  logic [30:0]             m1, m2;
  logic [30:0]             m1_r, m2_r;
  tri_flags_t              fl_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]    q1, q2;
  logic [16:0]             den;
  logic signed [TRI_W-1:0] q1s, q2s, term1, term23, term_eq;
  logic signed [TRI_W-1:0] tv_r;

  // Setup: sawtooth, reversed saw and region of each term
  always_comb begin
    rev_u    = ~u + 32'd1;
    saw      = signed'({u[CYC_W-1], u});
    rev      = signed'({rev_u[CYC_W-1], rev_u});
    a31      = signed'({2'b00, a, 15'd0});
    abs_saw  = saw[TRI_W-1] ? -saw : saw;
    fl.t1div = (a != '0) && (abs_saw < a31);
    fl.t1eq  = (a != '0) && (abs_saw == a31);
    fl.t1neg = saw[TRI_W-1];
    fl.rlt   = rev < -a31;
    fl.reqn  = rev == -a31;
    fl.rgt   = rev > a31;
    fl.reqp  = rev == a31;
    m1       = fl.t1div ? abs_saw[30:0] : '0;
    if (fl.rlt) begin
      m2 = 31'(rev + ONE31);
    end else if (fl.rgt) begin
      m2 = 31'(ONE31 - rev);
    end else begin
      m2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r     <= m1;
      m2_r     <= m2;
      fl_r[0]  <= fl;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // Rising part divides by a, falling part by 1 - a
  assign den = 17'h10000 - {1'b0, a};

  tssg_div u_div_rise (
    .clk (clk),
    .en  (en),
    .r0  (m1_r[30:15]),
    .lo  ({m1_r[14:0], {(DIV_STEPS-15){1'b0}}}),
    .d   ({1'b0, a}),
    .q   (q1)
  );

  tssg_div u_div_fall (
    .clk (clk),
    .en  (en),
    .r0  (m2_r[30:15]),
    .lo  ({m2_r[14:0], {(DIV_STEPS-15){1'b0}}}),
    .d   (den),
    .q   (q2)
  );

  // Combine terms; quotients truncate toward zero
  always_comb begin
    q1s = signed'({3'b000, q1});
    q2s = signed'({3'b000, q2});
    if (fl_r[DIV_STEPS].t1div) begin
      term1 = fl_r[DIV_STEPS].t1neg ? -q1s : q1s;
    end else if (fl_r[DIV_STEPS].t1eq) begin
      term1 = fl_r[DIV_STEPS].t1neg ? -HALF : HALF;
    end else begin
      term1 = '0;
    end
    if (fl_r[DIV_STEPS].rlt) begin
      term23 = q2s;
    end else if (fl_r[DIV_STEPS].rgt) begin
      term23 = -q2s;
    end else begin
      term23 = '0;
    end
    term_eq = (fl_r[DIV_STEPS].reqn ? HALF : '0) - (fl_r[DIV_STEPS].reqp ? HALF : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tv_r <= term1 + term23 + term_eq;
    end
  end

  assign tv = tv_r;

endmodule

// File: src/tssg_shape.sv
`timescale 1ns / 1ps

module tssg_shape (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tssg_pkg::TRI_W-1:0] tv0,
  input  logic signed [tssg_pkg::TRI_W-1:0] tv1,
  input  logic [tssg_pkg::PAIR_W-1:0]       squareness_pair,
  input  logic [tssg_pkg::PAIR_W-1:0]       amplitude_pair,
  input  logic [tssg_pkg::ANG_W-1:0]        center_offset,
  input  logic [tssg_pkg::ANG_W-1:0]        angle_min,
  input  logic [tssg_pkg::ANG_W-1:0]        angle_max,
  output logic [tssg_pkg::ANG_W-1:0]        set_point,
  output logic                              clamped
);
  import tssg_pkg::*;

  localparam logic [33:0] ONE30 = 34'h0_4000_0000;

  logic signed [SHP_W-1:0] w0_r, w1_r;
  logic signed [PRD_W-1:0] p0_r, p1_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [VAL_W-1:0] val_r, lo, hi;
  logic [ANG_W-1:0]        set_point_r;
  logic                    clamped_r;

  // Square shaping and polarity mask of one half-wave, at double scale
  function automatic logic signed [SHP_W-1:0] shape_w(
    input logic signed [TRI_W-1:0] t,
    input logic [FRAC_W-1:0]       s,
    input logic                    neg_half
  );
    logic [TRI_W-1:0]        abs_t;
    logic [33:0]             sum;
    logic signed [SHP_W-1:0] sqr;
    logic signed [SHP_W-1:0] base;
    logic                    pos;
    abs_t = t[TRI_W-1] ? 33'(-t) : 33'(t);
    sum   = 34'(abs_t) + 34'({s, 14'd0});
    if (s != '0 && sum >= ONE30) begin
      sqr = signed'(36'({17'h10000 - {1'b0, s}, 14'd0}));
    end else begin
      sqr = '0;
    end
    if (neg_half) begin
      sqr = -sqr;
    end
    base = sqr + ((sum <= ONE30) ? signed'({{(SHP_W-TRI_W){t[TRI_W-1]}}, t}) : '0);
    pos  = neg_half ? t[TRI_W-1] : (!t[TRI_W-1] && t != '0);
    if (pos) begin
      return base <<< 1;
    end else if (t == '0) begin
      return base;
    end
    return '0;
  endfunction

  // Final sum at Q.31 scale, rounded to Q8.8
  assign acc = signed'({{(ACC_W-ANG_W-31){center_offset[ANG_W-1]}}, center_offset, 31'd0})
             + ACC_W'(p0_r) + ACC_W'(p1_r) + signed'(ACC_W'(ONE30));

  assign lo = VAL_W'(signed'(angle_min));
  assign hi = VAL_W'(signed'(angle_max));

  always_ff @(posedge clk) begin
    if (en) begin
      w0_r  <= shape_w(tv0, squareness_pair[15:0], 1'b0);
      w1_r  <= shape_w(tv1, squareness_pair[31:16], 1'b1);
      p0_r  <= PRD_W'(signed'(amplitude_pair[15:0])) * PRD_W'(w0_r);
      p1_r  <= PRD_W'(signed'(amplitude_pair[31:16])) * PRD_W'(w1_r);
      val_r <= acc[ACC_W-1:31];
      // max test first, then min
      if (val_r > hi) begin
        set_point_r <= angle_max;
        clamped_r   <= 1'b1;
      end else if (val_r < lo) begin
        set_point_r <= angle_min;
        clamped_r   <= 1'b1;
      end else begin
        set_point_r <= val_r[ANG_W-1:0];
        clamped_r   <= 1'b0;
      end
    end
  end

  assign set_point = set_point_r;
  assign clamped   = clamped_r;

endmodule

// File: src/triangle_square_waveform_generator_top.sv
`timescale 1ns / 1ps

// Asymmetric triangle/square waveform generator. Each transfer on the input
// stream carries an elapsed time in microseconds; each result is one clamped
// servo set-point (Q8.8 degrees) with a flag that shows it hit a limit. The
// block takes one time sample per clock unless a result waits untaken, and returns
// results in order through the cycle-fraction arithmetic, the triangle (two
// 30-step restoring divider pipelines per half-wave) and shaping, scaling and
// clamping. While a valid result is not taken the whole pipeline holds. Registers
// are written over the cfg port, which is always ready; write them only while
// no sample is in flight.
module triangle_square_waveform_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream: tdata = elapsed_us[31:0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,
  // result stream: tdata = set_point[15:0]; tuser = clamped[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,
  output logic [0:0]                       out_tuser,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tssg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tssg_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import tssg_pkg::*;

  logic [FREQ_W-1:0]       frequency_r;
  logic [FRAC_W-1:0]       phase_shift_r;
  logic [ANG_W-1:0]        center_offset_r;
  logic [PAIR_W-1:0]       amplitude_pair_r;
  logic [PAIR_W-1:0]       skew_pair_r;
  logic [PAIR_W-1:0]       squareness_pair_r;
  logic [ANG_W-1:0]        angle_min_r;
  logic [ANG_W-1:0]        angle_max_r;

  logic [PIPE_LAT-1:0]     vld_r;
  logic                    en;
  logic [CYC_W-1:0]        u;
  logic signed [TRI_W-1:0] tv0, tv1;
  logic [ANG_W-1:0]        set_point;
  logic                    clamped;

  // Register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frequency_r       <= 24'd65536;
      phase_shift_r     <= '0;
      center_offset_r   <= '0;
      amplitude_pair_r  <= '0;
      skew_pair_r       <= 32'h8000_8000;
      squareness_pair_r <= '0;
      angle_min_r       <= 16'hA600;
      angle_max_r       <= 16'h5A00;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FREQUENCY:  frequency_r       <= cfg_data[FREQ_W-1:0];
        REG_PHASE:      phase_shift_r     <= cfg_data[FRAC_W-1:0];
        REG_OFFSET:     center_offset_r   <= cfg_data[ANG_W-1:0];
        REG_AMPLITUDE:  amplitude_pair_r  <= cfg_data[PAIR_W-1:0];
        REG_SKEW:       skew_pair_r       <= cfg_data[PAIR_W-1:0];
        REG_SQUARENESS: squareness_pair_r <= cfg_data[PAIR_W-1:0];
        REG_ANGLE_MIN:  angle_min_r       <= cfg_data[ANG_W-1:0];
        REG_ANGLE_MAX:  angle_max_r       <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: all stages move unless the output holds a result not taken
  assign en        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  tssg_phase u_phase (
    .clk         (clk),
    .en          (en),
    .t           (in_tdata[TIME_W-1:0]),
    .frequency   (frequency_r),
    .phase_shift (phase_shift_r),
    .u           (u)
  );

  tssg_tri u_tri_pos (
    .clk (clk),
    .en  (en),
    .u   (u),
    .a   (skew_pair_r[15:0]),
    .tv  (tv0)
  );

  tssg_tri u_tri_neg (
    .clk (clk),
    .en  (en),
    .u   (u),
    .a   (skew_pair_r[31:16]),
    .tv  (tv1)
  );

  tssg_shape u_shape (
    .clk             (clk),
    .en              (en),
    .tv0             (tv0),
    .tv1             (tv1),
    .squareness_pair (squareness_pair_r),
    .amplitude_pair  (amplitude_pair_r),
    .center_offset   (center_offset_r),
    .angle_min       (angle_min_r),
    .angle_max       (angle_max_r),
    .set_point       (set_point),
    .clamped         (clamped)
  );

  assign out_tvalid   = vld_r[PIPE_LAT-1];
  assign out_tdata    = set_point;
  assign out_tuser[0] = clamped;

  // A held result stalls the input side too
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // A clamped result sits on one of the limits
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == angle_max_r || out_tdata == angle_min_r))
    else $error("clamped result off the limits");

  // An unclamped result lies within the limits
  a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      ($signed(out_tdata) <= $signed(angle_max_r) && $signed(out_tdata) >= $signed(angle_min_r)))
    else $error("unclamped result outside limits");

endmodule

// File: test/tb_triangle_square_waveform_generator_top.sv
`timescale 1ns / 1ps

module tb_triangle_square_waveform_generator_top;
  import tssg_pkg::*;

  localparam longint ONE31      = 64'sd2147483648;
  localparam longint ONE30      = 64'sd1073741824;
  localparam logic [63:0] CYCLE_MOD = 64'd65536000000;
  localparam int     STALL_LIMIT = 3000;
  localparam int     DRAIN_CYCLES = 2 * PIPE_LAT + 10;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_INDEX = 8'hFF;

  typedef struct packed {
    logic [15:0] set_point;
    logic        clamped;
  } servo_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // register shadow, updated on each accepted cfg transfer
  logic [23:0] freq_r   = 24'd65536;
  logic [15:0] phase_r  = '0;
  logic [15:0] offset_r = '0;
  logic [31:0] amp_r    = '0;
  logic [31:0] skew_r   = 32'h80008000;
  logic [31:0] sq_r     = '0;
  logic [15:0] min_r    = 16'hA600;
  logic [15:0] max_r    = 16'h5A00;

  logic [31:0] pending_times[$];
  servo_cmd_t  expected_cmds[$];
  int          n_errors = 0;
  int          n_results = 0;
  int          n_clamped = 0;
  int          n_phases = 0;
  bit          steady = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          quiet_cycles = 0;

  triangle_square_waveform_generator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // asymmetric triangle, Q2.30, from saw/rev (Q1.31) and skew (Q0.16)
  function automatic longint asym_tri(longint saw, longint rev, longint a);
    longint a31;
    longint abs_saw;
    longint den;
    longint res;
    a31 = a * 32768;
    abs_saw = (saw < 0) ? -saw : saw;
    den = 65536 - a;
    res = 0;
    if (a != 0) begin
      if (abs_saw < a31) res += saw * 32768 / a;
      else if (abs_saw == a31) res += saw * 16384 / a;
    end
    if (rev < -a31) res += (rev + ONE31) * 32768 / den;
    else if (rev == -a31) res += (rev + ONE31) * 16384 / den;
    if (rev > a31) res += (rev - ONE31) * 32768 / den;
    else if (rev == a31) res += (rev - ONE31) * 16384 / den;
    return res;
  endfunction

  // servo command for one time sample under the current registers
  function automatic servo_cmd_t servo_setpoint(logic [31:0] t_us);
    logic [63:0] t;
    logic [63:0] rem;
    logic [63:0] u;
    logic [31:0] neg_u;
    longint saw, rev, acc, val, lo, hi;
    longint a, s, amp, tv, abs_t, sum, sqr, ceil_v, tri_v, pol2;
    servo_cmd_t r;
    t = {32'b0, t_us};
    rem = ((t % CYCLE_MOD) * {40'b0, freq_r}) % CYCLE_MOD;
    u = ((rem << 16) / 64'd1000000) & 64'hFFFFFFFF;
    if (t != 0) u = (u + ({48'b0, phase_r} << 16)) & 64'hFFFFFFFF;
    neg_u = -u[31:0];
    saw = longint'($signed(u[31:0]));
    rev = longint'($signed(neg_u));
    acc = longint'($signed(offset_r)) * ONE31;
    for (int i = 0; i < 2; i++) begin
      a = longint'({48'b0, skew_r[16*i +: 16]});
      s = longint'({48'b0, sq_r[16*i +: 16]});
      amp = longint'($signed(amp_r[16*i +: 16]));
      tv = asym_tri(saw, rev, a);
      abs_t = (tv < 0) ? -tv : tv;
      sum = abs_t + s * 16384;
      sqr = 0;
      if (s != 0 && sum >= ONE30) sqr = (65536 - s) * 16384;
      if (i == 1) sqr = -sqr;
      ceil_v = (sum == 0) ? 0 : ((sum <= ONE30) ? 1 : 2);
      tri_v = (ceil_v - 2) * tv;
      if (i == 0) pol2 = (tv > 0) ? 2 : ((tv == 0) ? 1 : 0);
      else pol2 = (tv < 0) ? 2 : ((tv == 0) ? 1 : 0);
      acc += amp * pol2 * (sqr - tri_v);
    end
    val = (acc + ONE30) >>> 31;
    lo = longint'($signed(min_r));
    hi = longint'($signed(max_r));
    r.clamped = 1'b0;
    if (val > hi) begin
      val = hi;
      r.clamped = 1'b1;
    end else if (val < lo) begin
      val = lo;
      r.clamped = 1'b1;
    end
    r.set_point = val[15:0];
    return r;
  endfunction

  // register shadow
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FREQUENCY:  freq_r   <= cfg_data[23:0];
        REG_PHASE:      phase_r  <= cfg_data[15:0];
        REG_OFFSET:     offset_r <= cfg_data[15:0];
        REG_AMPLITUDE:  amp_r    <= cfg_data;
        REG_SKEW:       skew_r   <= cfg_data;
        REG_SQUARENESS: sq_r     <= cfg_data;
        REG_ANGLE_MIN:  min_r    <= cfg_data[15:0];
        REG_ANGLE_MAX:  max_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input driver: predicts on each accepted transfer, idles in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_cmds.insert(expected_cmds.size(), servo_setpoint(in_tdata));
      if (in_tvalid && !in_tready) begin
        // hold the current transfer
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_times.size() > 0) begin
        if (!steady && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(1, 14) - 1;
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_times.pop_front();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    servo_cmd_t exp_cmd;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result sp=%h clamped=%b", $time, out_tdata, out_tuser);
          n_errors++;
        end else begin
          exp_cmd = expected_cmds.pop_front();
          n_results++;
          if (exp_cmd.clamped) n_clamped++;
          if (out_tdata !== exp_cmd.set_point) begin
            $display("%0t: set_point expected %h actual %h", $time,
                     exp_cmd.set_point, out_tdata);
            n_errors++;
          end
          if (out_tuser[0] !== exp_cmd.clamped) begin
            $display("%0t: clamped expected %b actual %b", $time,
                     exp_cmd.clamped, out_tuser[0]);
            n_errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 14) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with work pending but no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || (pending_times.size() == 0 && expected_cmds.size() == 0 && !in_tvalid))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until all samples are through, then let the pipeline empty
  task automatic drain();
    while (pending_times.size() > 0 || expected_cmds.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_phases++;
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4, 5: return 32'($urandom_range(0, 400)) * 32'd15625;
      6:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 3000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_setup();
    logic [15:0] lim_a, lim_b;
    write_reg(REG_FREQUENCY, ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0)
              ? 32'hFFFFFF : 32'd1) : 32'($urandom_range(1, 1500000)));
    write_reg(REG_PHASE, {16'b0, rand_frac()});
    write_reg(REG_OFFSET, $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
              : 32'($signed(16'($urandom_range(0, 12000) - 6000))));
    write_reg(REG_AMPLITUDE, ($urandom_range(0, 4) == 0) ? $urandom()
              : {16'($urandom_range(0, 40000) - 20000), 16'($urandom_range(0, 40000) - 20000)});
    write_reg(REG_SKEW, {rand_frac(), rand_frac()});
    write_reg(REG_SQUARENESS, {rand_frac(), rand_frac()});
    lim_a = 16'($urandom_range(0, 30000) - 30000);
    lim_b = 16'($urandom_range(0, 30000));
    if ($urandom_range(0, 5) == 0) begin
      write_reg(REG_ANGLE_MIN, {16'b0, lim_b});
      write_reg(REG_ANGLE_MAX, {16'b0, lim_a});
    end else begin
      write_reg(REG_ANGLE_MIN, {16'b0, lim_a});
      write_reg(REG_ANGLE_MAX, {16'b0, lim_b});
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: boundaries of time and quarter cycles at 1 Hz
    pending_times = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 32'd250000,
                      32'd500000, 32'd750000, 32'd1000000};
    drain();

    // symmetric triangle with amplitude and shaped edges
    write_reg(REG_AMPLITUDE, 32'hE2001E00);
    write_reg(REG_SQUARENESS, 32'h8000FFFF);
    write_reg(UNMAPPED_INDEX, 32'hFFFFFFFF);
    pending_times = '{32'd0, 32'd125000, 32'd250000, 32'd375000, 32'd500000, 32'd625000,
                      32'd750000, 32'd875000, 32'd999999, 32'd1000000, 32'hFFFFFFFF};
    drain();

    // zero skew, zero frequency, full phase, extremes, min above max
    write_reg(REG_SKEW, 32'h00000000);
    write_reg(REG_FREQUENCY, 32'd0);
    write_reg(REG_PHASE, 32'h0000FFFF);
    write_reg(REG_OFFSET, 32'h00008000);
    write_reg(REG_AMPLITUDE, 32'h80007FFF);
    write_reg(REG_ANGLE_MIN, 32'h00002000);
    write_reg(REG_ANGLE_MAX, 32'h0000E000);
    pending_times = '{32'd0, 32'd1, 32'd77, 32'hFFFFFFFF};
    drain();
    write_reg(REG_FREQUENCY, 32'hFFFFFF);
    write_reg(REG_SKEW, 32'hFFFF0000);
    write_reg(REG_OFFSET, 32'h00007FFF);
    write_reg(REG_ANGLE_MIN, 32'h00008000);
    write_reg(REG_ANGLE_MAX, 32'h00007FFF);
    pending_times = '{32'd0, 32'd3, 32'd15625, 32'hFFFFFFFF};
    drain();

    // random settings and samples; the last phase runs without idling
    for (int ph = 0; ph < 9; ph++) begin
      random_setup();
      if (ph == 8) steady = 1'b1;
      for (int k = 0; k < 48; k++) pending_times.insert(pending_times.size(), rand_time());
      drain();
    end

    $display("Covered %0d setting phases, %0d results (%0d clamped).",
             n_phases, n_results, n_clamped);
    if (n_errors == 0 && expected_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
